### hdl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Types and constants shared by the Targa RLE pixel decoder modules.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam logic [7:0] TYPE_RAW   = 8'd2;
    localparam logic [7:0] TYPE_RLE   = 8'd10;
    localparam logic [7:0] BPP_24     = 8'd24;
    localparam logic [7:0] BPP_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_TYPE  = 2'd1;
    localparam logic [1:0] STATUS_BAD_DEPTH = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] start_column;
        logic [15:0] dest_row;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_PIXEL,
        CMD_STATUS
    } t_cmd_kind;

    // START carries the geometry, PIXEL a color and count, STATUS a final code.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  count;
        logic        done;
        logic [1:0]  status;
        logic [15:0] width;
        logic [15:0] first_row;
    } t_cmd;

endpackage

### hdl/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front
// Byte parser: header, ID skip, packet headers and pixel assembly. Emits one
// command per byte at most.
// ----------------------------------------------------------------------------
module trd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trd_pkg::t_in  i_data,
    input  logic          i_cmd_full,
    output logic          o_cmd_push,
    output trd_pkg::t_cmd o_cmd
);
    import trd_pkg::*;

    typedef enum logic [5:0] {
        PH_WAIT   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_IDSKIP = 6'b000100,
        PH_PKTHDR = 6'b001000,
        PH_PIXEL  = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_TYPE      = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_BPP       = 5'd16;
    localparam logic [4:0] HDR_LAST      = 5'd17;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hdr_idx, n_hdr_idx;
    logic [7:0]  r_id_skip, n_id_skip;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_bpp, n_bpp;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run, n_pkt_run;
    logic [1:0]  r_pix_idx, n_pix_idx;
    logic [3:0][7:0] r_pix, n_pix;

    logic        accept;
    logic        start;
    t_phase      ph;
    logic [4:0]  idx;
    logic [7:0]  b;
    logic [7:0]  cnt;
    logic [1:0]  last_idx;
    logic [31:0] left_after;

    assign accept = i_push && !i_cmd_full;
    assign b      = i_data.in_byte;

    always_comb begin
        n_phase       = r_phase;
        n_hdr_idx     = r_hdr_idx;
        n_id_skip     = r_id_skip;
        n_kind        = r_kind;
        n_bpp         = r_bpp;
        n_width       = r_width;
        n_height      = r_height;
        n_pixels_left = r_pixels_left;
        n_pkt_left    = r_pkt_left;
        n_pkt_run     = r_pkt_run;
        n_pix_idx     = r_pix_idx;
        n_pix         = r_pix;
        o_cmd_push    = 1'b0;
        o_cmd         = '0;
        start         = 1'b0;
        cnt           = 8'd1;
        left_after    = r_pixels_left;
        last_idx      = (r_bpp == BPP_32) ? 2'd3 : 2'd2;
        ph            = i_data.file_start ? PH_HEADER : r_phase;
        idx           = i_data.file_start ? 5'd0 : r_hdr_idx;

        if (accept) begin
            if (i_data.file_start) begin
                n_kind   = '0;
                n_bpp    = '0;
                n_width  = '0;
                n_height = '0;
                n_pix    = {ALPHA_OPAQUE, 8'd0, 8'd0, 8'd0};
                n_phase  = PH_HEADER;
            end
            case (ph)
                PH_HEADER: begin
                    case (idx)
                        HDR_ID_LEN:    n_id_skip = b;
                        HDR_TYPE:      n_kind = b;
                        HDR_WIDTH_LO:  n_width[7:0] = b;
                        HDR_WIDTH_HI:  n_width[15:8] = b;
                        HDR_HEIGHT_LO: n_height[7:0] = b;
                        HDR_HEIGHT_HI: n_height[15:8] = b;
                        HDR_BPP:       n_bpp = b;
                        default: ;
                    endcase
                    n_hdr_idx = idx + 5'd1;
                    if (idx == HDR_LAST) begin
                        if (r_kind != TYPE_RAW && r_kind != TYPE_RLE) begin
                            o_cmd_push   = 1'b1;
                            o_cmd.kind   = CMD_STATUS;
                            o_cmd.done   = 1'b1;
                            o_cmd.status = STATUS_BAD_TYPE;
                            n_phase      = PH_DONE;
                        end else if (r_bpp != BPP_24 && r_bpp != BPP_32) begin
                            o_cmd_push   = 1'b1;
                            o_cmd.kind   = CMD_STATUS;
                            o_cmd.done   = 1'b1;
                            o_cmd.status = STATUS_BAD_DEPTH;
                            n_phase      = PH_DONE;
                        end else if (r_id_skip != 8'd0) begin
                            n_phase = PH_IDSKIP;
                        end else begin
                            start = 1'b1;
                        end
                    end
                end
                PH_IDSKIP: begin
                    n_id_skip = r_id_skip - 8'd1;
                    if (n_id_skip == 8'd0) begin
                        start = 1'b1;
                    end
                end
                PH_PKTHDR: begin
                    n_pkt_left = (b & PKT_COUNT_MASK) + 8'd1;
                    n_pkt_run  = b[7];
                    n_pix_idx  = 2'd0;
                    n_phase    = PH_PIXEL;
                end
                PH_PIXEL: begin
                    n_pix[r_pix_idx] = b;
                    n_pix_idx = r_pix_idx + 2'd1;
                    if (r_pix_idx == last_idx) begin
                        n_pix_idx = 2'd0;
                        if (r_kind == TYPE_RLE && r_pkt_run) begin
                            cnt        = r_pkt_left;
                            n_pkt_left = 8'd0;
                        end else if (r_pkt_left != 8'd0) begin
                            n_pkt_left = r_pkt_left - 8'd1;
                        end
                        if ({24'd0, cnt} > r_pixels_left) begin
                            cnt = r_pixels_left[7:0];
                        end
                        left_after    = r_pixels_left - {24'd0, cnt};
                        n_pixels_left = left_after;
                        o_cmd_push    = 1'b1;
                        o_cmd.kind    = CMD_PIXEL;
                        o_cmd.red     = n_pix[2];
                        o_cmd.green   = n_pix[1];
                        o_cmd.blue    = n_pix[0];
                        o_cmd.alpha   = n_pix[3];
                        o_cmd.count   = cnt;
                        o_cmd.done    = (left_after == 32'd0);
                        o_cmd.status  = STATUS_OK;
                        if (left_after == 32'd0) begin
                            n_phase = PH_DONE;
                        end else if (r_kind == TYPE_RLE && n_pkt_left == 8'd0) begin
                            n_phase = PH_PKTHDR;
                        end
                    end
                end
                default: ;
            endcase

            if (start) begin
                n_pixels_left = {16'd0, r_width} * {16'd0, r_height};
                n_pkt_left    = 8'd0;
                n_pkt_run     = 1'b0;
                n_pix_idx     = 2'd0;
                o_cmd_push    = 1'b1;
                if (r_width == 16'd0 || r_height == 16'd0) begin
                    o_cmd.kind   = CMD_STATUS;
                    o_cmd.done   = 1'b1;
                    o_cmd.status = STATUS_OK;
                    n_phase      = PH_DONE;
                end else begin
                    o_cmd.kind      = CMD_START;
                    o_cmd.width     = r_width;
                    o_cmd.first_row = r_height - 16'd1;
                    n_phase         = (r_kind == TYPE_RLE) ? PH_PKTHDR : PH_PIXEL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT;
            r_hdr_idx     <= '0;
            r_id_skip     <= '0;
            r_kind        <= '0;
            r_bpp         <= '0;
            r_width       <= '0;
            r_height      <= '0;
            r_pixels_left <= '0;
            r_pkt_left    <= '0;
            r_pkt_run     <= 1'b0;
            r_pix_idx     <= '0;
        end else begin
            r_phase       <= n_phase;
            r_hdr_idx     <= n_hdr_idx;
            r_id_skip     <= n_id_skip;
            r_kind        <= n_kind;
            r_bpp         <= n_bpp;
            r_width       <= n_width;
            r_height      <= n_height;
            r_pixels_left <= n_pixels_left;
            r_pkt_left    <= n_pkt_left;
            r_pkt_run     <= n_pkt_run;
            r_pix_idx     <= n_pix_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

endmodule

### hdl/trd_queue.sv
// ----------------------------------------------------------------------------
// trd_queue
// Small command FIFO between the parser and the pixel placer.
// ----------------------------------------------------------------------------
module trd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output trd_pkg::t_cmd o_data,
    output logic          o_empty
);
    import trd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hdl/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back
// Pixel placer: turns pixel and status commands into results and advances
// column and row with a divider settling four quotient bits per cycle.
// ----------------------------------------------------------------------------
module trd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trd_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    output trd_pkg::t_out o_data,
    output logic          o_empty,
    input  logic          i_pop
);
    import trd_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'b001,
        BK_DIV_HI = 3'b010,
        BK_DIV_LO = 3'b100
    } t_bk_state;

    t_bk_state   r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;
    logic [15:0] r_width, n_width;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [16:0] r_rem, n_rem;
    logic [7:0]  r_quo, n_quo;
    logic [22:0] r_dvs, n_dvs;

    logic        slot_free;
    logic        take;
    logic [16:0] rem;
    logic [7:0]  quo;
    logic [22:0] dvs_k;

    assign slot_free = !r_out_valid || i_pop;
    assign take      = (r_state == BK_IDLE) && !i_cmd_empty &&
                       (i_cmd.kind == CMD_START || slot_free);
    assign o_cmd_pop = take;
    assign o_data    = r_out;
    assign o_empty   = !r_out_valid;

    always_comb begin
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < 4; k++) begin
            dvs_k = r_dvs >> k;
            if ({6'd0, rem} >= dvs_k) begin
                rem = rem - dvs_k[16:0];
                quo = {quo[6:0], 1'b1};
            end else begin
                quo = {quo[6:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_width     = r_width;
        n_col       = r_col;
        n_row       = r_row;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;

        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_IDLE: begin
                if (take) begin
                    case (i_cmd.kind)
                        CMD_START: begin
                            n_width = i_cmd.width;
                            n_col   = 16'd0;
                            n_row   = i_cmd.first_row;
                        end
                        CMD_PIXEL: begin
                            n_out_valid        = 1'b1;
                            n_out.red          = i_cmd.red;
                            n_out.green        = i_cmd.green;
                            n_out.blue         = i_cmd.blue;
                            n_out.alpha        = i_cmd.alpha;
                            n_out.start_column = r_col;
                            n_out.dest_row     = r_row;
                            n_out.repeat_count = i_cmd.count;
                            n_out.image_done   = i_cmd.done;
                            n_out.status       = STATUS_OK;
                            n_rem   = {1'b0, r_col} + {9'd0, i_cmd.count};
                            n_quo   = 8'd0;
                            n_dvs   = {r_width, 7'd0};
                            n_state = BK_DIV_HI;
                        end
                        CMD_STATUS: begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.image_done = i_cmd.done;
                            n_out.status     = i_cmd.status;
                        end
                        default: ;
                    endcase
                end
            end
            BK_DIV_HI: begin
                n_rem   = rem;
                n_quo   = quo;
                n_dvs   = r_dvs >> 4;
                n_state = BK_DIV_LO;
            end
            BK_DIV_LO: begin
                n_col   = rem[15:0];
                n_row   = r_row - {8'd0, quo};
                n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_width <= n_width;
        r_col   <= n_col;
        r_row   <= n_row;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
    end

endmodule

### hdl/targa_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// targa_rle_pixel_decoder
// Targa (type 2 / type 10, 24 or 32 bpp) byte stream to RGBA pixel spans.
// ----------------------------------------------------------------------------
// One file byte is accepted per cycle when full is low. The parser handles
// every byte in the cycle it arrives and posts at most one command into a
// QUEUE_DEPTH-entry queue. The placer turns each pixel command into a result
// held in an output register and takes no command until its column/row
// divider, four quotient bits a cycle, is through BK_DIV_HI and BK_DIV_LO.
// A pixel needs at least three file bytes, so a steady stream runs at one
// byte per cycle; full rises only while the consumer holds pop low (for
// QUEUE_DEPTH above one). Header and ID bytes give at most a status result.
// ----------------------------------------------------------------------------
module targa_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  trd_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output trd_pkg::t_out o_data
);
    import trd_pkg::*;

    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    assign full = cmd_full;

    trd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    trd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_data      (o_data),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
